@@ rtl/dll_pkg.sv @@
// ----------------------------------------------------------------------------
// Doubly linked list engine package
// Shared constants for the list engine: request codes, status codes and the
// default pool size.
// ----------------------------------------------------------------------------
package dll_pkg;

   localparam int DEFAULT_CAPACITY = 16;

   localparam int FUNC_W   = 3;
   localparam int STATUS_W = 2;
   localparam int DATA_W   = 32;

   // Request codes.
   localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_INS_BEFORE = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_INS_AFTER  = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_LIST       = 3'd7;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

endpackage

@@ rtl/dll_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module dll_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/doubly_linked_list_engine.sv @@
// ----------------------------------------------------------------------------
// Doubly linked list engine
// Ordered list of signed 32-bit values in a pool of CAPACITY nodes with
// forward and backward links, driven by a small sequencer.
// ----------------------------------------------------------------------------
// Insert before/after searches for the key from the front, one node per compare;
// the search and the listing walk the links through the registered node memories.
// One request is in flight at a time; a new word is taken in the cycle after the
// last result is registered. Reset empties the list at once; no clearing pass.
module doubly_linked_list_engine
   #(
   parameter int CAPACITY = dll_pkg::DEFAULT_CAPACITY
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [dll_pkg::FUNC_W-1:0]    req_func,
   input  logic signed [dll_pkg::DATA_W-1:0] req_value,
   input  logic signed [dll_pkg::DATA_W-1:0] req_key,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [dll_pkg::STATUS_W-1:0]  rsp_status,
   output logic signed [dll_pkg::DATA_W-1:0] rsp_data,
   output logic                          rsp_last
);
   import dll_pkg::*;

   localparam int PW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam logic [PW-1:0] NIL = PW'(CAPACITY);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_ALLOC    = 4'd2;
   localparam logic [3:0] S_LINK1    = 4'd3;
   localparam logic [3:0] S_LINK2    = 4'd4;
   localparam logic [3:0] S_SRCH_RD  = 4'd5;
   localparam logic [3:0] S_SRCH_CMP = 4'd6;
   localparam logic [3:0] S_POP_RD   = 4'd7;
   localparam logic [3:0] S_POP      = 4'd8;
   localparam logic [3:0] S_LIST_RD  = 4'd9;
   localparam logic [3:0] S_LIST_EM  = 4'd10;
   localparam logic [3:0] S_FINISH   = 4'd11;

   logic [3:0]           state_ff, state_in;
   logic [FUNC_W-1:0]    func_ff, func_in;
   logic [DATA_W-1:0]    value_ff, value_in;
   logic [DATA_W-1:0]    key_ff, key_in;
   logic [PW-1:0]        head_ff, head_in, tail_ff, tail_in;
   logic [PW-1:0]        count_ff, count_in, bump_ff, bump_in, fsp_ff, fsp_in;
   logic [PW-1:0]        p_ff, p_in, n_ff, n_in, a_ff, a_in, b_ff, b_in;
   logic [STATUS_W-1:0]  res_st_ff, res_st_in;
   logic [DATA_W-1:0]    res_data_ff, res_data_in;
   logic                 rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   logic              data_we, next_we, prev_we, free_we;
   logic [AW-1:0]     data_wa, next_wa, prev_wa, free_wa, free_ra;
   logic [DATA_W-1:0] data_wd, data_rd;
   logic [PW-1:0]     next_wd, prev_wd, free_wd, next_rd, prev_rd, free_rd;
   logic              can_emit, key_hit;

   // Node memories, read at the current walk pointer.
   dll_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_data (
      .clock(clock), .wr_en(data_we), .wr_addr(data_wa), .wr_data(data_wd),
      .rd_addr(p_ff[AW-1:0]), .rd_data(data_rd));
   dll_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_next (
      .clock(clock), .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
      .rd_addr(p_ff[AW-1:0]), .rd_data(next_rd));
   dll_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_prev (
      .clock(clock), .wr_en(prev_we), .wr_addr(prev_wa), .wr_data(prev_wd),
      .rd_addr(p_ff[AW-1:0]), .rd_data(prev_rd));

   // Stack of released nodes; never-used nodes come from the bump counter.
   assign free_ra = fsp_ff[AW-1:0] - AW'(1);
   dll_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_free (
      .clock(clock), .wr_en(free_we), .wr_addr(free_wa), .wr_data(free_wd),
      .rd_addr(free_ra), .rd_data(free_rd));

   assign can_emit  = !rsp_valid_ff || !rsp_stall;
   assign key_hit   = (data_rd == key_ff);
   assign req_stall = (state_ff != S_IDLE);

   // Sequencer.
   always_comb begin
      state_in = state_ff;   func_in = func_ff;   value_in = value_ff;
      key_in = key_ff;       head_in = head_ff;   tail_in = tail_ff;
      count_in = count_ff;   bump_in = bump_ff;   fsp_in = fsp_ff;
      p_in = p_ff;  n_in = n_ff;  a_in = a_ff;  b_in = b_ff;
      res_st_in = res_st_ff; res_data_in = res_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff; rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      data_we = 1'b0; data_wa = n_ff[AW-1:0]; data_wd = value_ff;
      next_we = 1'b0; next_wa = n_ff[AW-1:0]; next_wd = b_ff;
      prev_we = 1'b0; prev_wa = n_ff[AW-1:0]; prev_wd = a_ff;
      free_we = 1'b0; free_wa = fsp_ff[AW-1:0]; free_wd = p_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in = req_func; value_in = req_value; key_in = req_key;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            res_st_in = ST_OK; res_data_in = '0;
            state_in = S_FINISH;
            case (func_ff)
               FUNC_CLEAR: begin
                  head_in = NIL; tail_in = NIL; count_in = '0;
                  bump_in = '0;  fsp_in = '0;
               end
               FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
                  a_in = (func_ff == FUNC_PUSH_FRONT) ? NIL : tail_ff;
                  b_in = (func_ff == FUNC_PUSH_FRONT) ? head_ff : NIL;
                  if (count_ff == NIL) res_st_in = ST_FULL;
                  else state_in = S_ALLOC;
               end
               FUNC_INS_BEFORE, FUNC_INS_AFTER: begin
                  p_in = head_ff;
                  if (count_ff == NIL) res_st_in = ST_FULL;
                  else if (head_ff == NIL) res_st_in = ST_EMPTY;
                  else state_in = S_SRCH_RD;
               end
               FUNC_POP_FRONT, FUNC_POP_BACK: begin
                  p_in = (func_ff == FUNC_POP_FRONT) ? head_ff : tail_ff;
                  if (p_in == NIL) res_st_in = ST_EMPTY;
                  else state_in = S_POP_RD;
               end
               default: begin
                  p_in = head_ff;
                  if (head_ff == NIL) res_st_in = ST_EMPTY;
                  else state_in = S_LIST_RD;
               end
            endcase
         end
         S_SRCH_RD: state_in = S_SRCH_CMP;
         S_SRCH_CMP: begin
            // One compare per node walked from the front.
            if (key_hit) begin
               a_in = (func_ff == FUNC_INS_BEFORE) ? prev_rd : p_ff;
               b_in = (func_ff == FUNC_INS_BEFORE) ? p_ff : next_rd;
               state_in = S_ALLOC;
            end else if (next_rd == NIL) begin
               res_st_in = ST_NOT_FOUND;
               state_in = S_FINISH;
            end else begin
               p_in = next_rd;
               state_in = S_SRCH_RD;
            end
         end
         S_ALLOC: begin
            if (fsp_ff != '0) begin
               n_in = free_rd; fsp_in = fsp_ff - PW'(1);
            end else begin
               n_in = bump_ff; bump_in = bump_ff + PW'(1);
            end
            state_in = S_LINK1;
         end
         S_LINK1: begin
            data_we = 1'b1; next_we = 1'b1; prev_we = 1'b1;
            state_in = S_LINK2;
         end
         S_LINK2: begin
            // Hook the new node into its neighbors or the ends.
            if (a_ff != NIL) begin
               next_we = 1'b1; next_wa = a_ff[AW-1:0]; next_wd = n_ff;
            end else head_in = n_ff;
            if (b_ff != NIL) begin
               prev_we = 1'b1; prev_wa = b_ff[AW-1:0]; prev_wd = n_ff;
            end else tail_in = n_ff;
            count_in = count_ff + PW'(1);
            res_st_in = ST_OK;
            state_in = S_FINISH;
         end
         S_POP_RD: state_in = S_POP;
         S_POP: begin
            // Unlink the end node and return it to the stack.
            if (prev_rd != NIL) begin
               next_we = 1'b1; next_wa = prev_rd[AW-1:0]; next_wd = next_rd;
            end else head_in = next_rd;
            if (next_rd != NIL) begin
               prev_we = 1'b1; prev_wa = next_rd[AW-1:0]; prev_wd = prev_rd;
            end else tail_in = prev_rd;
            free_we = 1'b1;
            fsp_in = fsp_ff + PW'(1);
            count_in = count_ff - PW'(1);
            res_st_in = ST_OK; res_data_in = data_rd;
            state_in = S_FINISH;
         end
         S_LIST_RD: state_in = S_LIST_EM;
         S_LIST_EM: begin
            if (can_emit) begin
               rsp_valid_in = 1'b1; rsp_status_in = ST_OK;
               rsp_data_in = data_rd; rsp_last_in = (next_rd == NIL);
               p_in = next_rd;
               state_in = (next_rd == NIL) ? S_IDLE : S_LIST_RD;
            end
         end
         S_FINISH: begin
            if (can_emit) begin
               rsp_valid_in = 1'b1; rsp_status_in = res_st_ff;
               rsp_data_in = res_data_ff; rsp_last_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; head_ff <= NIL; tail_ff <= NIL;
         count_ff <= '0; bump_ff <= '0; fsp_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; head_ff <= head_in; tail_ff <= tail_in;
         count_ff <= count_in; bump_ff <= bump_in; fsp_ff <= fsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      func_ff <= func_in; value_ff <= value_in; key_ff <= key_in;
      p_ff <= p_in; n_ff <= n_in; a_ff <= a_in; b_ff <= b_in;
      res_st_ff <= res_st_in; res_data_ff <= res_data_in;
      rsp_status_ff <= rsp_status_in; rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

@@ verif/tb_doubly_linked_list_engine.sv @@
// ----------------------------------------------------------------------------
// Doubly linked list engine testbench
// Drives list requests through the valid/stall request port with random gaps,
// predicts every response word with a behavioral copy of the list, and checks
// the responses in order while the response side stalls at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_doubly_linked_list_engine;
   import dll_pkg::*;

   localparam int CAP = DEFAULT_CAPACITY;
   localparam int NIL = CAP;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] key;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] data;
      logic                     last;
   } rsp_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [FUNC_W-1:0] req_func = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic signed [DATA_W-1:0] req_key = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic signed [DATA_W-1:0] rsp_data;
   logic rsp_last;

   req_word_type pending_reqs[$];
   rsp_word_type expected_rsps[$];
   int  errors = 0;
   int  accepted_reqs = 0;
   int  checked_rsps = 0;
   longint cycle_count = 0;
   int  op_seen[8];

   // Shadow copy of the node pool.
   logic signed [DATA_W-1:0] shadow_data[CAP];
   int  shadow_next[CAP];
   int  shadow_prev[CAP];
   bit  shadow_free[CAP];
   int  shadow_head, shadow_tail, shadow_count;

   doubly_linked_list_engine dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   function automatic void empty_shadow();
      for (int i = 0; i < CAP; i++) shadow_free[i] = 1'b1;
      shadow_head = NIL;
      shadow_tail = NIL;
      shadow_count = 0;
   endfunction

   function automatic void push_rsp(logic [STATUS_W-1:0] st, logic signed [DATA_W-1:0] d,
                                    logic lst);
      rsp_word_type w;
      w.status = st;
      w.data = d;
      w.last = lst;
      expected_rsps.push_back(w);
   endfunction

   function automatic int grab_node();
      for (int i = 0; i < CAP; i++)
         if (shadow_free[i]) begin
            shadow_free[i] = 1'b0;
            return i;
         end
      return NIL;
   endfunction

   function automatic void link_node(int n, int a, int b);
      shadow_prev[n] = a;
      shadow_next[n] = b;
      if (a < CAP) shadow_next[a] = n; else shadow_head = n;
      if (b < CAP) shadow_prev[b] = n; else shadow_tail = n;
      shadow_count++;
   endfunction

   // Works out the response words of one request and updates the shadow list.
   function automatic void predict_list_op(req_word_type r);
      int p, n, steps;
      case (r.func)
         FUNC_CLEAR: begin
            empty_shadow();
            push_rsp(ST_OK, '0, 1'b1);
         end
         FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
            n = grab_node();
            if (n >= CAP) push_rsp(ST_FULL, '0, 1'b1);
            else begin
               shadow_data[n] = r.value;
               if (r.func == FUNC_PUSH_FRONT) link_node(n, NIL, shadow_head);
               else link_node(n, shadow_tail, NIL);
               push_rsp(ST_OK, '0, 1'b1);
            end
         end
         FUNC_INS_BEFORE, FUNC_INS_AFTER: begin
            if (shadow_count >= CAP) push_rsp(ST_FULL, '0, 1'b1);
            else if (shadow_head >= CAP) push_rsp(ST_EMPTY, '0, 1'b1);
            else begin
               p = shadow_head;
               steps = 0;
               while (steps < CAP && p < CAP && shadow_data[p] != r.key) begin
                  p = shadow_next[p];
                  steps++;
               end
               if (steps >= CAP) p = NIL;
               if (p >= CAP) push_rsp(ST_NOT_FOUND, '0, 1'b1);
               else begin
                  n = grab_node();
                  shadow_data[n] = r.value;
                  if (r.func == FUNC_INS_BEFORE) link_node(n, shadow_prev[p], p);
                  else link_node(n, p, shadow_next[p]);
                  push_rsp(ST_OK, '0, 1'b1);
               end
            end
         end
         FUNC_POP_FRONT, FUNC_POP_BACK: begin
            p = (r.func == FUNC_POP_FRONT) ? shadow_head : shadow_tail;
            if (p >= CAP) push_rsp(ST_EMPTY, '0, 1'b1);
            else begin
               if (shadow_prev[p] < CAP) shadow_next[shadow_prev[p]] = shadow_next[p];
               else shadow_head = shadow_next[p];
               if (shadow_next[p] < CAP) shadow_prev[shadow_next[p]] = shadow_prev[p];
               else shadow_tail = shadow_prev[p];
               shadow_free[p] = 1'b1;
               if (shadow_count > 0) shadow_count--;
               push_rsp(ST_OK, shadow_data[p], 1'b1);
            end
         end
         default: begin
            p = shadow_head;
            if (p >= CAP) push_rsp(ST_EMPTY, '0, 1'b1);
            else
               for (steps = 0; steps < CAP && p < CAP; steps++) begin
                  n = shadow_next[p];
                  push_rsp(ST_OK, shadow_data[p],
                           (n >= CAP || steps == CAP - 1) ? 1'b1 : 1'b0);
                  p = n;
               end
         end
      endcase
   endfunction

   function automatic logic signed [DATA_W-1:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $signed(32'($urandom_range(0, 7)));
         default: return $signed($urandom());
      endcase
   endfunction

   function automatic void queue_req(logic [FUNC_W-1:0] f, logic signed [DATA_W-1:0] v,
                                     logic signed [DATA_W-1:0] k);
      req_word_type r;
      r.func = f;
      r.value = v;
      r.key = k;
      pending_reqs.push_back(r);
   endfunction

   // Stimulus: directed corner cases first, then random request mixes.
   initial begin
      logic [FUNC_W-1:0] f;
      logic signed [DATA_W-1:0] k;
      int mode;
      queue_req(FUNC_LIST, 0, 0);
      queue_req(FUNC_POP_FRONT, 0, 0);
      queue_req(FUNC_POP_BACK, 0, 0);
      queue_req(FUNC_INS_BEFORE, 5, 5);
      queue_req(FUNC_INS_AFTER, 5, 5);
      queue_req(FUNC_PUSH_BACK, 32'sh7fffffff, 0);
      queue_req(FUNC_POP_FRONT, 0, 0);
      queue_req(FUNC_PUSH_FRONT, 32'sh80000000, 0);
      queue_req(FUNC_POP_BACK, 0, 0);
      queue_req(FUNC_PUSH_BACK, 10, 0);
      queue_req(FUNC_INS_BEFORE, 9, 10);
      queue_req(FUNC_INS_AFTER, 11, 10);
      queue_req(FUNC_INS_AFTER, 3, 99);
      queue_req(FUNC_LIST, 0, 0);
      for (int i = 0; i < CAP - 3; i++) queue_req(FUNC_PUSH_BACK, -i, 0);
      queue_req(FUNC_PUSH_FRONT, 1, 0);
      queue_req(FUNC_INS_BEFORE, 1, 10);
      queue_req(FUNC_LIST, 0, 0);
      queue_req(FUNC_CLEAR, 0, 0);
      queue_req(FUNC_LIST, 0, 0);
      // Random part: key hits dominate, keys mostly come from a small value set.
      for (int i = 0; i < 438; i++) begin
         mode = $urandom_range(0, 99);
         if (mode < 2) f = FUNC_CLEAR;
         else if (mode < 40) f = $urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
         else if (mode < 65) f = $urandom_range(0, 1) ? FUNC_INS_BEFORE : FUNC_INS_AFTER;
         else if (mode < 88) f = $urandom_range(0, 1) ? FUNC_POP_FRONT : FUNC_POP_BACK;
         else f = FUNC_LIST;
         k = (mode % 4 != 0) ? $signed(32'($urandom_range(0, 7))) : rand_word();
         queue_req(f, (mode % 3 == 0) ? rand_word() : $signed(32'($urandom_range(0, 7))), k);
      end
   end

   // Stall seen at the last rising edge, so the driver knows if its word went in.
   logic req_stall_q = 1'b1;
   always @(posedge clock) begin
      req_stall_q <= req_stall;
      if (!reset && req_valid && !req_stall) predict_list_op({req_func, req_value, req_key});
   end

   // Driver: holds each word until accepted, then waits a random gap.
   int req_gap = 0;
   always @(negedge clock) begin
      req_word_type r;
      if (!reset) begin
         if (req_valid && !req_stall_q) begin
            accepted_reqs <= accepted_reqs + 1;
         end
         if (!req_valid || !req_stall_q) begin
            if (req_gap > 0 || pending_reqs.size() == 0) begin
               req_valid <= 1'b0;
               if (req_gap > 0) req_gap <= req_gap - 1;
            end else begin
               r = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_func <= r.func;
               req_value <= r.value;
               req_key <= r.key;
               req_gap <= (cycle_count < 3000 || $urandom_range(0, 2) == 0) ? 0
                          : $urandom_range(0, 9);
            end
         end
      end
   end

   // Response stall: random runs of stall, with stretches of none.
   int rsp_hold = 0;
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (cycle_count > 1500 && $urandom_range(0, 3) == 0) rsp_hold <= $urandom_range(0, 9);
      end
   end

   // Monitor: compares each accepted response word with the oldest prediction.
   always @(posedge clock) begin
      rsp_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected response: status %0d data %0d last %0d",
                   rsp_status, rsp_data, rsp_last);
            errors++;
         end else begin
            w = expected_rsps.pop_front();
            checked_rsps++;
            if (rsp_status !== w.status) begin
               $error("status: expected %0d, got %0d", w.status, rsp_status);
               errors++;
            end
            if (rsp_data !== w.data) begin
               $error("data: expected %0d, got %0d", w.data, rsp_data);
               errors++;
            end
            if (rsp_last !== w.last) begin
               $error("last: expected %0d, got %0d", w.last, rsp_last);
               errors++;
            end
         end
      end
   end

   always @(posedge clock)
      if (!reset && req_valid && !req_stall) op_seen[req_func]++;

   // Reset, run to completion, report.
   initial begin
      empty_shadow();
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0) begin
         @(posedge clock);
         if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
         end
      end
      repeat (50) @(posedge clock);
      $display("%0d requests accepted, %0d response words checked", accepted_reqs,
               checked_rsps);
      $display("ops clear..list: %0d %0d %0d %0d %0d %0d %0d %0d", op_seen[0], op_seen[1],
               op_seen[2], op_seen[3], op_seen[4], op_seen[5], op_seen[6], op_seen[7]);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
